// ===== sv/mvc_pkg.sv =====
// shared constants, codes and inter-module structs for the multichannel pi valve controller
package mvc_pkg;

  // channel count and integral store geometry
  localparam int CHANNELS  = 64;
  localparam int MEM_DEPTH = (CHANNELS < 64) ? CHANNELS : 64;
  localparam int MEM_AW    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

  // field widths
  localparam int CH_W    = 6;
  localparam int VAL_W   = 16;
  localparam int DIFF_W  = VAL_W + 1;
  localparam int PROD_W  = 33;
  localparam int Q_W     = 24;
  localparam int INTEG_W = 23;
  localparam int PCL_W   = 15;
  localparam int DRIVE_W = 7;
  localparam int DIV_CNT_W = $clog2(Q_W + 1);

  // stream port widths
  localparam int S_TDATA_W = 72;
  localparam int S_TUSER_W = 4;
  localparam int M_TDATA_W = 16;
  localparam int M_TUSER_W = 1;

  // fixed point limits: 100 percent in q.16 and in q.8
  localparam logic [INTEG_W-1:0] INT_MAX_Q16 = 23'd6553600;
  localparam logic [PCL_W-1:0]   P_MAX_Q8    = 15'd25600;

  // valve mode codes
  typedef enum logic [1:0] {
    MODE_HEAT   = 2'd0,
    MODE_COOL   = 2'd1,
    MODE_SEASON = 2'd2,
    MODE_NONE   = 2'd3
  } valve_mode_t;

  // divider request and response
  typedef struct packed {
    logic              start;
    logic [PROD_W-1:0] mag;
    logic [VAL_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic           done;
    logic           sat;
    logic [Q_W-1:0] quot;
  } div_rsp_t;

  // integral store write port
  typedef struct packed {
    logic               en;
    logic [MEM_AW-1:0]  addr;
    logic [INTEG_W-1:0] data;
  } store_wr_t;

endpackage

// ===== sv/mvc_div.sv =====
// bit-serial restoring divider for the integral increment, one quotient bit per cycle
module mvc_div (
  input  logic            clk,
  input  logic            rst,
  input  mvc_pkg::div_req_t req,
  output mvc_pkg::div_rsp_t rsp
);
  import mvc_pkg::*;

  logic [VAL_W-1:0]     rem;
  logic [Q_W-1:0]       shq;
  logic [VAL_W-1:0]     dvs;
  logic [DIV_CNT_W-1:0] cnt;
  logic                 busy;
  logic                 done;
  logic                 sat;

  logic [VAL_W:0]   trial;
  logic             ge;
  logic [VAL_W-1:0] rem_next;

  // one restoring step: shift in the next dividend bit and try the subtract
  always_comb begin
    trial    = {rem, shq[Q_W-1]};
    ge       = (trial >= {1'b0, dvs});
    rem_next = ge ? VAL_W'(trial - {1'b0, dvs}) : trial[VAL_W-1:0];
  end

  // sequencer and shift registers; quotient bits fill shq from the bottom
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        // quotient saturates once mag * 256 / divisor reaches 2^24
        sat  <= (req.mag >= {1'b0, req.divisor, 16'b0});
        rem  <= req.mag[31:16];
        shq  <= {req.mag[15:0], 8'b0};
        dvs  <= req.divisor;
        cnt  <= DIV_CNT_W'(Q_W);
        busy <= 1'b1;
      end else if (busy) begin
        rem <= rem_next;
        shq <= {shq[Q_W-2:0], ge};
        cnt <= cnt - 1'b1;
        if (cnt == DIV_CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done;
  assign rsp.sat  = sat;
  assign rsp.quot = shq;

endmodule

// ===== sv/mvc_integ_store.sv =====
// per-channel integral memory with reset-cleared valid bits
module mvc_integ_store (
  input  logic                             clk,
  input  logic                             rst,
  input  logic [mvc_pkg::MEM_AW-1:0]       rd_addr,
  output logic [mvc_pkg::INTEG_W-1:0]      rd_data,
  input  mvc_pkg::store_wr_t               wr
);
  import mvc_pkg::*;

  logic [INTEG_W-1:0]   mem [MEM_DEPTH];
  logic [MEM_DEPTH-1:0] valid;
  logic [INTEG_W-1:0]   rd_mem;
  logic                 rd_vld;

  // memory write and registered read
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    rd_mem <= mem[rd_addr];
  end

  // valid bits: an entry never written reads as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      valid  <= '0;
      rd_vld <= 1'b0;
    end else begin
      if (wr.en) begin
        valid[wr.addr] <= 1'b1;
      end
      rd_vld <= valid[rd_addr];
    end
  end

  assign rd_data = rd_vld ? rd_mem : '0;

endmodule

// ===== sv/multichannel_pi_valve_control.sv =====
// top level of the multichannel pi valve controller with clamped output
// One request is handled at a time. A request that updates a loop passes through the
// bit-serial divider that forms the integral increment (proportional term * 256 /
// integral time) before s_tready rises again; disabled, no-action and out-of-range
// requests skip the divider. The result sits in an output register, so the next
// request is taken while a result still waits on m_tready.
// Each of the channels keeps a Q7.16 integral that reads as zero after reset.
module multichannel_pi_valve_control (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // channel, measured, setpoint, gain, integral_time, 2 bits zero pad
  input  logic [mvc_pkg::S_TDATA_W-1:0]   s_tdata,
  // season, enable, valve_mode
  input  logic [mvc_pkg::S_TUSER_W-1:0]   s_tuser,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // out_channel, drive, 3 bits zero pad
  output logic [mvc_pkg::M_TDATA_W-1:0]   m_tdata,
  // drive_written
  output logic [mvc_pkg::M_TUSER_W-1:0]   m_tuser
);
  import mvc_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_PROD, S_ABS, S_START, S_WAIT, S_UPD, S_OUT
  } state_t;

  state_t state;

  // request fields
  logic [CH_W-1:0]  in_channel;
  logic [VAL_W-1:0] in_measured;
  logic [VAL_W-1:0] in_setpoint;
  logic [VAL_W-1:0] in_gain;
  logic [VAL_W-1:0] in_itime;
  logic             in_season;
  logic             in_enable;
  valve_mode_t      in_mode;

  assign in_channel  = s_tdata[5:0];
  assign in_measured = s_tdata[21:6];
  assign in_setpoint = s_tdata[37:22];
  assign in_gain     = s_tdata[53:38];
  assign in_itime    = s_tdata[69:54];
  assign in_season   = s_tuser[0];
  assign in_enable   = s_tuser[1];
  assign in_mode     = valve_mode_t'(s_tuser[3:2]);

  // working registers
  logic [CH_W-1:0]          ch_reg;
  logic                     skip;
  logic                     written;
  logic signed [DIFF_W-1:0] diff_reg;
  logic [VAL_W-1:0]         gain_reg;
  logic [VAL_W-1:0]         itime_reg;
  logic signed [PROD_W-1:0] prod;
  logic [PROD_W-1:0]        mag;
  logic                     neg;
  logic [PCL_W-1:0]         pclamp;
  logic [INTEG_W-1:0]       store_val;
  logic [INTEG_W-1:0]       integ;

  // submodule links
  div_req_t           div_req;
  div_rsp_t           div_rsp;
  store_wr_t          st_wr;
  logic [INTEG_W-1:0] st_rd;

  // request decode
  logic                     accept;
  logic                     ch_ok;
  logic                     cooling;
  logic signed [DIFF_W-1:0] diff_next;
  logic signed [2*DIFF_W-1:0] prod_full;
  logic signed [25:0]       isum;
  logic [INTEG_W-1:0]       integ_next;
  logic [INTEG_W:0]         sum;
  logic [INTEG_W-1:0]       sum_cl;
  logic [DRIVE_W-1:0]       drive;

  assign accept   = s_tvalid && s_tready;
  assign s_tready = (state == S_IDLE);

  always_comb begin
    ch_ok   = (32'(in_channel) < CHANNELS);
    cooling = (in_mode == MODE_SEASON) ? in_season : (in_mode == MODE_COOL);
    if (cooling) begin
      diff_next = {in_measured[VAL_W-1], in_measured} - {in_setpoint[VAL_W-1], in_setpoint};
    end else begin
      diff_next = {in_setpoint[VAL_W-1], in_setpoint} - {in_measured[VAL_W-1], in_measured};
    end
  end

  // proportional product, gain is unsigned q8.8
  assign prod_full = $signed({1'b0, gain_reg}) * diff_reg;

  // integral update with the signed, saturating increment
  always_comb begin
    if (neg) begin
      isum = $signed({3'b0, store_val}) - $signed({2'b0, div_rsp.quot});
    end else begin
      isum = $signed({3'b0, store_val}) + $signed({2'b0, div_rsp.quot});
    end
    if (div_rsp.sat) begin
      integ_next = neg ? '0 : INT_MAX_Q16;
    end else if (isum < 0) begin
      integ_next = '0;
    end else if (isum > $signed({3'b0, INT_MAX_Q16})) begin
      integ_next = INT_MAX_Q16;
    end else begin
      integ_next = isum[INTEG_W-1:0];
    end
  end

  // drive: clamped p plus integral, clamped, integer part
  always_comb begin
    sum    = {1'b0, pclamp, 8'b0} + {1'b0, integ};
    sum_cl = (sum > {1'b0, INT_MAX_Q16}) ? INT_MAX_Q16 : sum[INTEG_W-1:0];
    drive  = skip ? '0 : sum_cl[INTEG_W-1:16];
  end

  // divider and store hookups
  assign div_req.start   = (state == S_START);
  assign div_req.mag     = mag;
  assign div_req.divisor = itime_reg;

  assign st_wr.en   = (state == S_UPD);
  assign st_wr.addr = ch_reg[MEM_AW-1:0];
  assign st_wr.data = integ_next;

  mvc_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  mvc_integ_store u_store (
    .clk     (clk),
    .rst     (rst),
    .rd_addr (in_channel[MEM_AW-1:0]),
    .rd_data (st_rd),
    .wr      (st_wr)
  );

  // control sequencer, datapath registers and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      // a taken result frees the output register unless a new one loads now
      if (m_tvalid && m_tready && (state != S_OUT)) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            ch_reg    <= in_channel;
            skip      <= !ch_ok || !in_enable || (in_mode == MODE_NONE);
            written   <= ch_ok && (!in_enable || (in_mode != MODE_NONE));
            diff_reg  <= diff_next;
            gain_reg  <= in_gain;
            itime_reg <= (in_itime == '0) ? VAL_W'(1) : in_itime;
            if (!ch_ok || !in_enable || (in_mode == MODE_NONE)) begin
              state <= S_OUT;
            end else begin
              state <= S_PROD;
            end
          end
        end
        S_PROD: begin
          prod      <= prod_full[PROD_W-1:0];
          store_val <= st_rd;
          state     <= S_ABS;
        end
        S_ABS: begin
          neg <= prod[PROD_W-1];
          mag <= prod[PROD_W-1] ? PROD_W'(-prod) : PROD_W'(prod);
          if (prod[PROD_W-1]) begin
            pclamp <= '0;
          end else if (prod > $signed({18'b0, P_MAX_Q8})) begin
            pclamp <= P_MAX_Q8;
          end else begin
            pclamp <= prod[PCL_W-1:0];
          end
          state <= S_START;
        end
        S_START: begin
          state <= S_WAIT;
        end
        S_WAIT: begin
          if (div_rsp.done) begin
            state <= S_UPD;
          end
        end
        S_UPD: begin
          integ <= integ_next;
          state <= S_OUT;
        end
        S_OUT: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {3'b0, drive, ch_reg};
            m_tuser  <= written;
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== sv/mvc_checker.sv =====
// port-level checks for the valve controller and the bind that attaches them
module mvc_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_tvalid,
  input logic                            s_tready,
  input logic [mvc_pkg::S_TDATA_W-1:0]   s_tdata,
  input logic [mvc_pkg::S_TUSER_W-1:0]   s_tuser,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [mvc_pkg::M_TDATA_W-1:0]   m_tdata,
  input logic [mvc_pkg::M_TUSER_W-1:0]   m_tuser
);
  import mvc_pkg::*;

  // drive never leaves the percent range
  a_drive_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[12:6] <= 7'd100))
    else $error("drive above 100 percent");

  // a result that is not written carries zero drive
  a_unwritten_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser[0]) |-> (m_tdata[12:6] == '0))
    else $error("unwritten result with nonzero drive");

  // one request at a time: ready drops after every accepted request
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("request accepted while busy");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
    else $error("stalled result changed");

endmodule

bind multichannel_pi_valve_control mvc_checker u_mvc_checker (.*);

// ===== sim/multichannel_pi_valve_control_test.sv =====
// testbench for the multichannel pi valve controller: directed, stall and random control updates
`timescale 1ns / 1ps

module multichannel_pi_valve_control_test;
  import mvc_pkg::*;

  localparam int LONG_STALL   = 400;
  localparam int SETTLE_LIMIT = 40;
  localparam int RANDOM_ITEMS = 1390;

  // one control update request as the sender sees it
  typedef struct {
    logic [CH_W-1:0]         channel;
    logic signed [VAL_W-1:0] measured;
    logic signed [VAL_W-1:0] setpoint;
    logic [VAL_W-1:0]        gain;
    logic [VAL_W-1:0]        itime;
    logic                    season;
    logic                    enable;
    valve_mode_t             mode;
  } pi_request_t;

  // one drive result
  typedef struct {
    logic [CH_W-1:0]    ch;
    logic [DRIVE_W-1:0] drive;
    logic               written;
  } drive_result_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata = '0;
  logic [S_TUSER_W-1:0] s_tuser = '0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_tdata;
  logic [M_TUSER_W-1:0] m_tuser;

  // predictor state: q7.16 integral per loop channel
  logic [INTEG_W-1:0] integ_q16 [CHANNELS];
  drive_result_t      expected_drives [$];
  int                 mismatch_count = 0;

  // idle controls shared by the test tasks and the receiver
  bit tx_no_gap = 1'b0;
  bit rx_no_stall = 1'b0;
  bit long_stall_req = 1'b0;
  int rx_hold_left = 0;

  multichannel_pi_valve_control u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  // 12 ns clock
  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // run limit
  initial begin
    #8_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic longint clamp_to(longint v, longint lo, longint hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  // expected drive for one request, updating the channel integral
  function automatic drive_result_t predict_drive(pi_request_t rq);
    drive_result_t res;
    logic          cool;
    longint        err, prop, inc, acc, total, tdiv;
    res.ch      = rq.channel;
    res.drive   = '0;
    res.written = 1'b0;
    if (rq.channel >= CHANNELS) return res;
    // disabled wins over the valve mode
    if (!rq.enable) begin
      res.written = 1'b1;
      return res;
    end
    if (rq.mode == MODE_NONE) return res;
    cool = (rq.mode == MODE_SEASON) ? rq.season : (rq.mode == MODE_COOL);
    tdiv = (rq.itime == 0) ? 64'sd1 : longint'(rq.itime);
    err  = longint'(rq.setpoint) - longint'(rq.measured);
    prop = longint'(rq.gain) * err;
    if (cool) prop = -prop;
    // integral gets the unclamped term, truncated toward zero
    inc  = (prop * 256) / tdiv;
    acc  = clamp_to(longint'(integ_q16[rq.channel]) + inc, 0, longint'(INT_MAX_Q16));
    integ_q16[rq.channel] = acc[INTEG_W-1:0];
    prop  = clamp_to(prop, 0, longint'(P_MAX_Q8));
    total = clamp_to(prop * 256 + acc, 0, longint'(INT_MAX_Q16));
    res.drive   = DRIVE_W'(total >>> 16);
    res.written = 1'b1;
    return res;
  endfunction

  function automatic pi_request_t make_request(int ch, int meas, int sp, int gain, int itime,
                                               bit season, bit enable, valve_mode_t mode);
    pi_request_t rq;
    rq.channel  = ch[CH_W-1:0];
    rq.measured = meas[VAL_W-1:0];
    rq.setpoint = sp[VAL_W-1:0];
    rq.gain     = gain[VAL_W-1:0];
    rq.itime    = itime[VAL_W-1:0];
    rq.season   = season;
    rq.enable   = enable;
    rq.mode     = mode;
    return rq;
  endfunction

  // mostly plausible loop updates on a few channels, some fully random noise
  function automatic pi_request_t random_request();
    pi_request_t rq;
    int          sp, diff;
    if ($urandom_range(0, 99) < 20) begin
      rq.channel  = CH_W'($urandom);
      rq.measured = VAL_W'($urandom);
      rq.setpoint = VAL_W'($urandom);
      rq.gain     = VAL_W'($urandom);
      rq.itime    = VAL_W'($urandom);
      rq.season   = 1'($urandom);
      rq.enable   = 1'($urandom);
    end else begin
      rq.channel  = ($urandom_range(0, 3) == 0) ? CH_W'($urandom_range(0, CHANNELS - 1))
                                                 : CH_W'($urandom_range(0, 7));
      sp          = int'($urandom_range(0, 4000)) - 2000;
      diff        = int'($urandom_range(0, 400)) - 200;
      rq.setpoint = sp[VAL_W-1:0];
      rq.measured = VAL_W'(sp + diff);
      rq.gain     = VAL_W'($urandom_range(0, 1024));
      rq.itime    = ($urandom_range(0, 9) == 0) ? '0 : VAL_W'($urandom_range(1, 300));
      rq.season   = 1'($urandom);
      rq.enable   = ($urandom_range(0, 9) != 0);
    end
    rq.mode = valve_mode_t'($urandom_range(0, 3));
    return rq;
  endfunction

  // idle length: mostly short, a few long
  function automatic int idle_length();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic report_mismatch(string what);
    mismatch_count++;
    if (mismatch_count <= 40) $display("ERROR at %0t: %s", $realtime, what);
  endtask

  // drive one request, record its expected drive when accepted, then maybe idle
  task automatic send_request(pi_request_t rq);
    int gap;
    s_tdata  = {2'b00, rq.itime, rq.gain, rq.setpoint, rq.measured, rq.channel};
    s_tuser  = {rq.mode, rq.enable, rq.season};
    s_tvalid = 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    expected_drives.push_back(predict_drive(rq));
    @(negedge clk);
    if (!tx_no_gap && $urandom_range(0, 99) < 40) begin
      gap      = idle_length();
      s_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  // hold the sender until every expected drive is back, then let the block settle
  task automatic wait_drained();
    s_tvalid = 1'b0;
    while (expected_drives.size() != 0) @(posedge clk);
    repeat (SETTLE_LIMIT) @(negedge clk);
  endtask

  // receiver side: random stalls, long hold-off on request
  always @(negedge clk) begin
    if (rst) begin
      m_tready = 1'b0;
    end else if (rx_hold_left > 0) begin
      m_tready = 1'b0;
      rx_hold_left--;
    end else if (long_stall_req) begin
      long_stall_req = 1'b0;
      m_tready       = 1'b0;
      rx_hold_left   = LONG_STALL - 1;
    end else if (rx_no_stall || $urandom_range(0, 99) < 75) begin
      m_tready = 1'b1;
    end else begin
      m_tready     = 1'b0;
      rx_hold_left = idle_length() - 1;
    end
  end

  // compare each accepted drive with the oldest expected one
  always @(posedge clk) begin : check_drives
    drive_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_drives.size() == 0) begin
        report_mismatch($sformatf("unexpected drive on channel %0d", m_tdata[5:0]));
      end else begin
        want = expected_drives.pop_front();
        if (m_tdata[5:0] !== want.ch)
          report_mismatch($sformatf("channel %0d, expected %0d", m_tdata[5:0], want.ch));
        if (m_tdata[12:6] !== want.drive)
          report_mismatch($sformatf("channel %0d drive %0d, expected %0d",
                                    want.ch, m_tdata[12:6], want.drive));
        if (m_tuser[0] !== want.written)
          report_mismatch($sformatf("channel %0d written %0b, expected %0b",
                                    want.ch, m_tuser[0], want.written));
      end
    end
  end

  // field extremes, every mode, disable and zero integral time
  task automatic test_directed_cases();
    send_request(make_request(0, 0, 0, 0, 0, 0, 1, MODE_HEAT));
    send_request(make_request(63, -32768, 32767, 65535, 65535, 0, 1, MODE_HEAT));
    send_request(make_request(63, -32768, 32767, 65535, 65535, 1, 1, MODE_COOL));
    send_request(make_request(1, 32767, -32768, 65535, 0, 1, 1, MODE_COOL));
    send_request(make_request(1, 32767, -32768, 65535, 0, 0, 1, MODE_HEAT));
    // 10 percent proportional, integral steps of 10 percent with zero time
    send_request(make_request(2, 0, 10, 256, 0, 0, 1, MODE_HEAT));
    send_request(make_request(2, 0, 10, 256, 0, 0, 0, MODE_HEAT));
    send_request(make_request(2, 0, 10, 256, 1, 0, 1, MODE_HEAT));
    send_request(make_request(2, 0, 10, 256, 1, 1, 1, MODE_NONE));
    send_request(make_request(2, 0, 10, 256, 65535, 0, 1, MODE_SEASON));
    send_request(make_request(2, 0, 10, 256, 65535, 1, 1, MODE_SEASON));
    send_request(make_request(2, 10, 0, 256, 3, 1, 1, MODE_SEASON));
    // disable takes priority over no action
    send_request(make_request(3, 5, 50, 512, 7, 0, 0, MODE_NONE));
    // truncation of small and negative increments
    send_request(make_request(4, 0, 1, 1, 3, 0, 1, MODE_HEAT));
    send_request(make_request(4, 0, 1, 1, 3, 0, 1, MODE_HEAT));
    send_request(make_request(4, 1, 0, 1, 3, 0, 1, MODE_HEAT));
    send_request(make_request(5, 100, 0, 300, 7, 0, 1, MODE_COOL));
    send_request(make_request(5, 100, 0, 300, 7, 0, 1, MODE_HEAT));
    send_request(make_request(62, 32767, 32767, 65535, 65535, 1, 1, MODE_SEASON));
    send_request(make_request(62, -1, 0, 65535, 1, 0, 1, MODE_HEAT));
    send_request(make_request(62, 0, -1, 65535, 1, 0, 1, MODE_HEAT));
    send_request(make_request(62, 0, 0, 0, 0, 1, 0, MODE_COOL));
  endtask

  // receiver holds off while the sender keeps offering, filling the block
  task automatic test_output_stall();
    tx_no_gap      = 1'b1;
    long_stall_req = 1'b1;
    repeat (16) send_request(random_request());
    tx_no_gap = 1'b0;
  endtask

  // sender pauses until all drives are back, several times
  task automatic test_drained_pause();
    repeat (6) begin
      repeat ($urandom_range(1, 8)) send_request(random_request());
      wait_drained();
    end
  endtask

  // bulk random updates with stretches free of idling on either side
  task automatic test_random_updates();
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 200 == 0) begin
        tx_no_gap   = ((i / 200) % 3 == 1);
        rx_no_stall = ((i / 200) % 3 != 0);
      end
      send_request(random_request());
    end
    tx_no_gap   = 1'b0;
    rx_no_stall = 1'b0;
  endtask

  initial begin
    foreach (integ_q16[i]) integ_q16[i] = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_directed_cases();
    test_output_stall();
    test_drained_pause();
    test_random_updates();
    wait_drained();
    if (mismatch_count == 0 && expected_drives.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
